// ===== hdl/dds_pkg.sv =====
package dds_pkg;

	localparam int PH_W  = 32;
	localparam int OUT_W = 18;
	localparam int ROM_W = 31;
	localparam int HP_W  = 33;

	localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
	localparam logic [63:0] HALF_PI_Q32 = (PI_Q60 + (64'd1 << 28)) >> 29;
	localparam logic [63:0] Q30_ONE     = 64'd1 << 30;

	localparam int SIN_TERMS = 6;
	localparam int COS_TERMS = 7;
	localparam logic [63:0] SIN_DIV [SIN_TERMS] = '{64'd156, 64'd110, 64'd72, 64'd42,
		64'd20, 64'd6};
	localparam logic [63:0] COS_DIV [COS_TERMS] = '{64'd182, 64'd132, 64'd90, 64'd56,
		64'd30, 64'd12, 64'd2};

	localparam int OUT_MAX     = 131071;
	localparam int OUT_MIN_MAG = 131072;

endpackage

// ===== hdl/dds_sine_cosine_top.sv =====
// Sine and cosine of a 32-bit phase word (one turn = 2^32). Takes one phase beat per clock
// while in_stall is low and returns one sine/cosine beat per phase beat, in order; the result
// is registered on the outputs by the last of the stages below. Six register
// stages: phase split and remainder-to-radian multiply, two reads of the quarter-wave ROM
// (2^TABLE_BITS+1 entries, built at elaboration), first-order products, second-order
// products, sum, then rounding to OUT_FRAC_BITS fractional bits with saturation to 18 bits.
// A stall freezes only the full stages at the end of the pipe; empty stages keep filling,
// so in_stall rises only when all six hold beats.
module dds_sine_cosine_top #(
	parameter int TABLE_BITS    = 10,
	parameter int OUT_FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [dds_pkg::PH_W-1:0]           phase,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [dds_pkg::OUT_W-1:0]   sine_out,
	output logic signed [dds_pkg::OUT_W-1:0]   cosine_out
);
	import dds_pkg::*;

	localparam int N       = 1 << TABLE_BITS;
	localparam int IDX_W   = TABLE_BITS + 1;
	localparam int REM_W   = 30 - TABLE_BITS;
	localparam int PROD_W  = REM_W + HP_W;
	localparam int DELTA_W = REM_W + 1;
	localparam int MS_W    = ROM_W + DELTA_W;
	localparam int QM_W    = 2 * DELTA_W;
	localparam int SUM_W   = 34;
	localparam int OUT_SH  = 30 - OUT_FRAC_BITS;
	localparam logic [SUM_W-1:0] OUT_RND = (SUM_W'(1) << OUT_SH) >> 1;

	function automatic logic [63:0] rnd_shr(input logic [63:0] v, input int sh);
		if (sh == 0)
			return v;
		return (v + (64'd1 << (sh - 1))) >> sh;
	endfunction

	// Quarter-wave sine: series in sine form below pi/4, cosine form above.
	function automatic logic [ROM_W-1:0] rom_entry(input int k);
		logic [63:0] j;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic use_sin;
		j = 64'(k);
		use_sin = (2 * j <= 64'(N));
		if (!use_sin)
			j = 64'(N) - j;
		x = rnd_shr(j * HALF_PI_Q32, TABLE_BITS + 2);
		x2 = rnd_shr(x * x, 30);
		t = Q30_ONE;
		if (use_sin) begin
			for (int i = 0; i < SIN_TERMS; i++)
				t = Q30_ONE - (rnd_shr(x2 * t, 30) + SIN_DIV[i] / 2) / SIN_DIV[i];
			t = rnd_shr(x * t, 30);
		end else begin
			for (int i = 0; i < COS_TERMS; i++)
				t = Q30_ONE - (rnd_shr(x2 * t, 30) + COS_DIV[i] / 2) / COS_DIV[i];
		end
		return t[ROM_W-1:0];
	endfunction

	logic [ROM_W-1:0] rom [0:N];

	for (genvar g = 0; g <= N; g++) begin : g_rom
		localparam logic [ROM_W-1:0] ENTRY = rom_entry(g);
		assign rom[g] = ENTRY;
	end

	function automatic logic [OUT_W-1:0] to_out(input logic [SUM_W-1:0] v);
		logic [SUM_W-1:0] mag;
		logic [SUM_W-1:0] r;
		logic [OUT_W-1:0] res;
		mag = v[SUM_W-1] ? SUM_W'(0) - v : v;
		r = (mag + OUT_RND) >> OUT_SH;
		if (v[SUM_W-1]) begin
			if (r >= SUM_W'(OUT_MIN_MAG))
				res = OUT_W'(OUT_MIN_MAG);
			else
				res = OUT_W'(SUM_W'(0) - r);
		end else begin
			if (r > SUM_W'(OUT_MAX))
				res = OUT_W'(OUT_MAX);
			else
				res = OUT_W'(r);
		end
		return res;
	endfunction

	logic [6:1] adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	// stage 1 inputs
	logic [1:0]            quad_in;
	logic [TABLE_BITS-1:0] idx_in;
	logic [IDX_W-1:0]      sidx_in;
	logic [REM_W-1:0]      rem_in;

	logic [IDX_W-1:0]   sidx_s1, cidx_s1;
	logic               sneg_s1, cneg_s1;
	logic [PROD_W-1:0]  prod_s1;

	logic [ROM_W-1:0]   smag_s2, cmag_s2;
	logic               sneg_s2, cneg_s2;
	logic [DELTA_W-1:0] delta_s2;

	logic [ROM_W-1:0]   smag_s3, cmag_s3;
	logic               sneg_s3, cneg_s3;
	logic [DELTA_W-1:0] delta_s3, sd_mag_s3, cd_mag_s3;

	logic [ROM_W-1:0]   smag_s4, cmag_s4;
	logic               sneg_s4, cneg_s4;
	logic [DELTA_W-1:0] sd_mag_s4, cd_mag_s4, qs_s4, qc_s4;

	logic [SUM_W-1:0]   s_s5, c_s5;

	logic [MS_W-1:0]    sd_full, cd_full;
	logic [QM_W-1:0]    qs_full, qc_full;
	logic [SUM_W-1:0]   s_part, c_part, s_cross, c_cross;

	// Squeeze out bubbles: a stage moves when it is empty or the next one moves.
	assign adv[6] = !vld_s6 || !out_stall;
	assign adv[5] = !vld_s5 || adv[6];
	assign adv[4] = !vld_s4 || adv[5];
	assign adv[3] = !vld_s3 || adv[4];
	assign adv[2] = !vld_s2 || adv[3];
	assign adv[1] = !vld_s1 || adv[2];
	assign in_stall  = !adv[1];
	assign out_valid = vld_s6;

	assign quad_in = phase[31:30];
	assign idx_in  = phase[29 -: TABLE_BITS];
	assign rem_in  = phase[REM_W-1:0];
	assign sidx_in = quad_in[0] ? IDX_W'(N) - {1'b0, idx_in} : {1'b0, idx_in};

	assign sd_full = MS_W'(smag_s2) * MS_W'(delta_s2);
	assign cd_full = MS_W'(cmag_s2) * MS_W'(delta_s2);
	assign qs_full = QM_W'(sd_mag_s3) * QM_W'(delta_s3);
	assign qc_full = QM_W'(cd_mag_s3) * QM_W'(delta_s3);

	// sin = +-(|S| - q_s) +- cd ; cos = +-(|C| - q_c) -+ sd
	assign s_part  = SUM_W'(smag_s4) - SUM_W'(qs_s4);
	assign c_part  = SUM_W'(cmag_s4) - SUM_W'(qc_s4);
	assign s_cross = cneg_s4 ? SUM_W'(0) - SUM_W'(cd_mag_s4) : SUM_W'(cd_mag_s4);
	assign c_cross = sneg_s4 ? SUM_W'(sd_mag_s4) : SUM_W'(0) - SUM_W'(sd_mag_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv[1])
				vld_s1 <= in_valid;
			if (adv[2])
				vld_s2 <= vld_s1;
			if (adv[3])
				vld_s3 <= vld_s2;
			if (adv[4])
				vld_s4 <= vld_s3;
			if (adv[5])
				vld_s5 <= vld_s4;
			if (adv[6])
				vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			sidx_s1 <= sidx_in;
			cidx_s1 <= IDX_W'(N) - sidx_in;
			sneg_s1 <= quad_in[1];
			cneg_s1 <= quad_in[1] ^ quad_in[0];
			prod_s1 <= PROD_W'(rem_in) * PROD_W'(HALF_PI_Q32[HP_W-1:0]);
		end
		if (adv[2]) begin
			smag_s2  <= rom[sidx_s1];
			cmag_s2  <= rom[cidx_s1];
			sneg_s2  <= sneg_s1;
			cneg_s2  <= cneg_s1;
			delta_s2 <= DELTA_W'((prod_s1 + (PROD_W'(1) << 31)) >> 32);
		end
		if (adv[3]) begin
			smag_s3   <= smag_s2;
			cmag_s3   <= cmag_s2;
			sneg_s3   <= sneg_s2;
			cneg_s3   <= cneg_s2;
			delta_s3  <= delta_s2;
			sd_mag_s3 <= DELTA_W'((sd_full + (MS_W'(1) << 29)) >> 30);
			cd_mag_s3 <= DELTA_W'((cd_full + (MS_W'(1) << 29)) >> 30);
		end
		if (adv[4]) begin
			smag_s4   <= smag_s3;
			cmag_s4   <= cmag_s3;
			sneg_s4   <= sneg_s3;
			cneg_s4   <= cneg_s3;
			sd_mag_s4 <= sd_mag_s3;
			cd_mag_s4 <= cd_mag_s3;
			qs_s4     <= DELTA_W'((qs_full + (QM_W'(1) << 30)) >> 31);
			qc_s4     <= DELTA_W'((qc_full + (QM_W'(1) << 30)) >> 31);
		end
		if (adv[5]) begin
			s_s5 <= (sneg_s4 ? SUM_W'(0) - s_part : s_part) + s_cross;
			c_s5 <= (cneg_s4 ? SUM_W'(0) - c_part : c_part) + c_cross;
		end
		if (adv[6]) begin
			sine_out   <= $signed(to_out(s_s5));
			cosine_out <= $signed(to_out(c_s5));
		end
	end

	a_full_pipe_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && vld_s2 && vld_s3 && vld_s4 && vld_s5 && vld_s6 && out_stall) |-> in_stall)
		else $error("input taken while every stage is full and output stalled");

	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !vld_s5) |=> !out_valid)
		else $error("output beat repeated after a bubble");

	a_stage3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && !adv[4]) |=> (vld_s3 && $stable(sd_mag_s3) && $stable(cd_mag_s3)))
		else $error("stage 3 beat lost or changed while blocked");

endmodule
